### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Assertion on the default clock and reset names.
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

### src/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// Shared constants, types and color mapping for the matrix row scanner.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int FRAME_PIXELS = 64;
  localparam int ROW_COUNT    = 8;
  localparam int COLUMNS      = 8;
  localparam int COL_W        = 3;
  localparam int BYTE_W       = 8;
  localparam int KIND_W       = 2;
  localparam int LINE_W       = 24;
  localparam int ROW_SEL_W    = 8;
  localparam int ROW_EXT_W    = 4;

  localparam logic [KIND_W-1:0] KIND_SPI     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CS_IDLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROW     = 2'd2;

  localparam logic [BYTE_W-1:0] CODE_RED   = 8'd1;
  localparam logic [BYTE_W-1:0] CODE_GREEN = 8'd2;
  localparam logic [BYTE_W-1:0] CODE_BLUE  = 8'd3;
  localparam logic [BYTE_W-1:0] CODE_RG    = 8'd4;
  localparam logic [BYTE_W-1:0] CODE_GB    = 8'd5;
  localparam logic [BYTE_W-1:0] CODE_BR    = 8'd6;
  localparam logic [BYTE_W-1:0] CODE_WHITE = 8'd7;

  localparam logic [LINE_W-1:0] RED_MASK [COLUMNS] = '{
    24'h000001, 24'h040000, 24'h000008, 24'h200000,
    24'h000040, 24'h010000, 24'h000200, 24'h002000
  };
  localparam logic [LINE_W-1:0] GREEN_MASK [COLUMNS] = '{
    24'h800000, 24'h000004, 24'h100000, 24'h000020,
    24'h000080, 24'h008000, 24'h000400, 24'h004000
  };
  localparam logic [LINE_W-1:0] BLUE_MASK [COLUMNS] = '{
    24'h000002, 24'h080000, 24'h000010, 24'h400000,
    24'h020000, 24'h000100, 24'h001000, 24'h000800
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPI_RD,
    S_SPI_WR,
    S_ROW_RD,
    S_ROW_DRAIN,
    S_ROW_OUT
  } state_e;

  typedef struct packed {
    logic             clear;
    logic             acc_en;
    logic [COL_W-1:0] col;
  } colour_ctrl_t;

  function automatic logic [LINE_W-1:0] colour_mask(
    input logic [BYTE_W-1:0] code,
    input logic [COL_W-1:0]  col
  );
    logic [LINE_W-1:0] r;
    logic [LINE_W-1:0] g;
    logic [LINE_W-1:0] b;
    logic [LINE_W-1:0] m;
    r = RED_MASK[col];
    g = GREEN_MASK[col];
    b = BLUE_MASK[col];
    case (code)
      CODE_RED:   m = r;
      CODE_GREEN: m = g;
      CODE_BLUE:  m = b;
      CODE_RG:    m = r | g;
      CODE_GB:    m = g | b;
      CODE_BR:    m = b | r;
      CODE_WHITE: m = r | g | b;
      default:    m = '0;
    endcase
    return m;
  endfunction

endpackage

### src/rgb_matrix_spi_frame_scanner.sv
// ----------------------------------------------------------------------------
// rgb_matrix_spi_frame_scanner
// Frame store and row-scan controller for an 8x8 RGB LED matrix.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start_i is high and busy_o is low.
//   kind_i = 0 writes spi_byte_i at the write index and returns the entry
//   after it as a reply; kind_i = 1 resets the write index with no result;
//   kind_i = 2 builds the next row line; kind_i = 3 is ignored.
//   A result beat is shown for one cycle with done_o high; the receiver
//   cannot stall it, so it must take every beat.
// Sequencing:
//   SPI byte: busy through S_SPI_RD and S_SPI_WR; done_o is registered from S_SPI_WR.
//   Row refresh: busy through S_ROW_RD, S_ROW_DRAIN and S_ROW_OUT; done_o is
//   registered from S_ROW_OUT; the eight pixel reads in S_ROW_RD go one per cycle
//   through the single RAM read port and the shared color unit.
//   Chip-select idle and unused kinds leave busy_o low.
// Reset:
//   The frame store reads as all zero until each entry is written (per
//   entry valid flags); write index and scan row clear to zero.
// ----------------------------------------------------------------------------
module rgb_matrix_spi_frame_scanner
  import rms_pkg::*;
#(
  parameter int FRAME_PIXELS = rms_pkg::FRAME_PIXELS,
  parameter int ROW_COUNT    = rms_pkg::ROW_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [BYTE_W-1:0]    spi_byte_i,
  output logic                 done_o,
  output logic                 is_line_o,
  output logic [BYTE_W-1:0]    reply_byte_o,
  output logic [LINE_W-1:0]    line_bits_o,
  output logic [ROW_SEL_W-1:0] row_select_o
);

`include "assert_macros.svh"

  localparam int AW = $clog2(FRAME_PIXELS);
  localparam int RW = $clog2(ROW_COUNT);

  state_e state_q, state_d;

  logic [AW-1:0]           widx_q, widx_d, widx_inc;
  logic [RW-1:0]           row_q, row_d;
  logic [AW-1:0]           base_q, base_d, base_inc;
  logic [AW:0]             base_sum;
  logic [AW-1:0]           pix_q, pix_d, pix_inc;
  logic [COL_W-1:0]        col_q, col_d;
  logic                    rd_act_q;
  logic [COL_W-1:0]        rd_col_q;
  logic [BYTE_W-1:0]       byte_q;
  logic [FRAME_PIXELS-1:0] vld_q;
  logic                    vld_rd_q;

  logic                    done_q;
  logic                    is_line_q;
  logic [BYTE_W-1:0]       reply_q;
  logic [LINE_W-1:0]       line_q;
  logic [ROW_SEL_W-1:0]    rsel_q;

  logic                    accept;
  logic [AW-1:0]           rd_addr;
  logic                    ram_we;
  logic [BYTE_W-1:0]       ram_rdata;
  logic [BYTE_W-1:0]       rd_byte;
  logic [LINE_W-1:0]       acc_line;
  logic [ROW_SEL_W-1:0]    rsel;
  logic [ROW_EXT_W-1:0]    row_ext;
  colour_ctrl_t            cu_ctrl;

  assign accept  = start_i && !busy_o;
  assign busy_o  = (state_q != S_IDLE);
  assign rd_byte = vld_rd_q ? ram_rdata : '0;

  assign widx_inc = (widx_q == AW'(FRAME_PIXELS - 1)) ? '0 : widx_q + 1'b1;
  assign pix_inc  = (pix_q == AW'(FRAME_PIXELS - 1)) ? '0 : pix_q + 1'b1;
  assign base_sum = {1'b0, base_q} + (AW + 1)'(COLUMNS);
  assign base_inc = (base_sum >= (AW + 1)'(FRAME_PIXELS)) ?
                    AW'(base_sum - (AW + 1)'(FRAME_PIXELS)) : AW'(base_sum);

  assign row_ext = ROW_EXT_W'(row_q);
  always_comb begin
    for (int i = 0; i < ROW_SEL_W; i++) begin
      rsel[i] = (row_ext == ROW_EXT_W'(i));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && kind_i == KIND_SPI) begin
          state_d = S_SPI_RD;
        end else if (accept && kind_i == KIND_ROW) begin
          state_d = S_ROW_RD;
        end
      end
      S_SPI_RD:    state_d = S_SPI_WR;
      S_SPI_WR:    state_d = S_IDLE;
      S_ROW_RD: begin
        if (col_q == COL_W'(COLUMNS - 1)) begin
          state_d = S_ROW_DRAIN;
        end
      end
      S_ROW_DRAIN: state_d = S_ROW_OUT;
      S_ROW_OUT:   state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    rd_addr        = pix_q;
    ram_we         = 1'b0;
    cu_ctrl.clear  = 1'b0;
    cu_ctrl.acc_en = rd_act_q;
    cu_ctrl.col    = rd_col_q;
    unique case (state_q)
      S_IDLE:   cu_ctrl.clear = accept && (kind_i == KIND_ROW);
      S_SPI_RD: rd_addr = widx_inc;
      S_SPI_WR: ram_we = 1'b1;
      S_ROW_RD, S_ROW_DRAIN, S_ROW_OUT: ;
      default:  ;
    endcase
  end

  // index and row bookkeeping
  always_comb begin
    widx_d = widx_q;
    row_d  = row_q;
    base_d = base_q;
    pix_d  = pix_q;
    col_d  = col_q;
    if (state_q == S_IDLE && accept && kind_i == KIND_CS_IDLE) begin
      widx_d = '0;
    end
    if (state_q == S_IDLE && accept && kind_i == KIND_ROW) begin
      pix_d = base_q;
      col_d = '0;
    end
    if (state_q == S_SPI_WR) begin
      widx_d = widx_inc;
    end
    if (state_q == S_ROW_RD) begin
      pix_d = pix_inc;
      col_d = col_q + 1'b1;
    end
    if (state_q == S_ROW_OUT) begin
      if (row_q == RW'(ROW_COUNT - 1)) begin
        row_d  = '0;
        base_d = '0;
      end else begin
        row_d  = row_q + 1'b1;
        base_d = base_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      widx_q   <= '0;
      row_q    <= '0;
      base_q   <= '0;
      pix_q    <= '0;
      col_q    <= '0;
      rd_act_q <= 1'b0;
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      widx_q   <= widx_d;
      row_q    <= row_d;
      base_q   <= base_d;
      pix_q    <= pix_d;
      col_q    <= col_d;
      rd_act_q <= (state_q == S_ROW_RD);
      vld_rd_q <= vld_q[rd_addr];
      if (ram_we) begin
        vld_q[widx_q] <= 1'b1;
      end
      done_q   <= (state_q == S_SPI_WR) || (state_q == S_ROW_OUT);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_col_q <= col_q;
    if (accept) begin
      byte_q <= spi_byte_i;
    end
    if (state_q == S_SPI_WR) begin
      is_line_q <= 1'b0;
      reply_q   <= rd_byte;
      line_q    <= '0;
      rsel_q    <= '0;
    end else if (state_q == S_ROW_OUT) begin
      is_line_q <= 1'b1;
      reply_q   <= '0;
      line_q    <= acc_line;
      rsel_q    <= rsel;
    end
  end

  rms_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_PIXELS)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (byte_q),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  rms_colour u_colour (
    .clk_i  (clk_i),
    .ctrl_i (cu_ctrl),
    .code_i (rd_byte),
    .line_o (acc_line)
  );

  assign done_o       = done_q;
  assign is_line_o    = is_line_q;
  assign reply_byte_o = reply_q;
  assign line_bits_o  = line_q;
  assign row_select_o = rsel_q;

  `ASSERT_DEF(a_busy_after_work, (accept && (kind_i == KIND_SPI || kind_i == KIND_ROW)) |=> busy_o)
  `ASSERT_DEF(a_spi_reply, (state_q == S_SPI_WR) |=> (done_o && !is_line_o))
  `ASSERT_DEF(a_no_double_beat, done_o |=> !done_o)
  `ASSERT_DEF(a_row_onehot, (done_o && is_line_o) |-> $onehot0(row_select_o))
  `ASSERT_DEF(a_drain_after_last, (state_q == S_ROW_DRAIN) |-> (rd_act_q && col_q == '0))

endmodule

### src/rms_ram.sv
// ----------------------------------------------------------------------------
// rms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/rms_colour.sv
// ----------------------------------------------------------------------------
// rms_colour
// Shared color unit: maps one pixel code per cycle and ORs it into the line; a clear resets it.
// ----------------------------------------------------------------------------
module rms_colour
  import rms_pkg::*;
(
  input  logic              clk_i,
  input  colour_ctrl_t      ctrl_i,
  input  logic [BYTE_W-1:0] code_i,
  output logic [LINE_W-1:0] line_o
);

  logic [LINE_W-1:0] acc_q;
  logic [LINE_W-1:0] acc_d;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_d = acc_q | colour_mask(code_i, ctrl_i.col);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign line_o = acc_q;

endmodule
